// ===== sv/rtsc_pkg.sv =====
package rtsc_pkg;

  // Largest frame the receive path accepts
  localparam logic [7:0] MaxFrameLen = 8'd127;

  // Frequency word is 357 + 5 * (channel - 11), folded to one offset
  localparam logic [9:0] FreqBase = 10'd302;

  // Energy floor and offset
  localparam logic signed [8:0] RssiFloor  = -9'sd81;
  localparam logic signed [7:0] EnergyMin  = -8'sd127;
  localparam logic signed [8:0] RssiOffset = 9'sd45;

  localparam logic [4:0] ChannelReset = 5'd11;

  typedef enum logic [3:0] {
    CMD_POWER_UP   = 4'd0,
    CMD_POWER_DOWN = 4'd1,
    CMD_TIMER      = 4'd2,
    CMD_POLL       = 4'd3,
    CMD_SFD        = 4'd4,
    CMD_FIFOP      = 4'd5,
    CMD_SET_STATE  = 4'd6,
    CMD_CCA        = 4'd7,
    CMD_ENERGY     = 4'd8,
    CMD_TRANSMIT   = 4'd9
  } cmd_t;

  typedef enum logic [2:0] {
    TGT_RX_ON     = 3'd0,
    TGT_RX_REJECT = 3'd1,
    TGT_TX_ON     = 3'd2,
    TGT_OFF       = 3'd3,
    TGT_FORCE_OFF = 3'd4
  } tgt_t;

  typedef enum logic [3:0] {
    ST_REG_OFF      = 4'd0,
    ST_WAIT_REG_ON  = 4'd1,
    ST_WAIT_REG_OFF = 4'd2,
    ST_POWERED_DOWN = 4'd3,
    ST_WAIT_OSC     = 4'd4,
    ST_IDLE         = 4'd5,
    ST_RX           = 4'd6,
    ST_RX_SFD       = 4'd7,
    ST_RX_READ      = 4'd8,
    ST_RX_REJECT    = 4'd9,
    ST_TX           = 4'd10,
    ST_TX_SFD       = 4'd11
  } state_t;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_DATA      = 3'd1,
    KIND_CCA       = 3'd2,
    KIND_ENERGY    = 3'd3,
    KIND_SET_STATE = 3'd4,
    KIND_FRAME     = 3'd5,
    KIND_CHANGED   = 3'd6,
    KIND_REJECTED  = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    STAT_SUCCESS      = 4'd0,
    STAT_OFF          = 4'd1,
    STAT_RX_ON        = 4'd2,
    STAT_TX_ON        = 4'd3,
    STAT_IDLE         = 4'd4,
    STAT_BUSY         = 4'd5,
    STAT_BUSY_TX      = 4'd6,
    STAT_BUSY_RX      = 4'd7,
    STAT_POWERED_UP   = 4'd8,
    STAT_POWERED_DOWN = 4'd9
  } status_t;

  typedef enum logic [3:0] {
    ACT_NONE          = 4'd0,
    ACT_RX_ON         = 4'd1,
    ACT_RF_OFF        = 4'd2,
    ACT_TX_START      = 4'd3,
    ACT_FLUSH_RX      = 4'd4,
    ACT_RESET_OSC_ON  = 4'd5,
    ACT_RESET_OSC_OFF = 4'd6,
    ACT_FLUSH_TX_LOAD = 4'd7,
    ACT_CONFIGURE     = 4'd8
  } action_t;

  typedef struct packed {
    logic [3:0]        command;
    logic [2:0]        target_state;
    logic              osc_stable;
    logic              tx_active;
    logic              tx_underflow;
    logic              channel_clear;
    logic signed [7:0] rssi_raw;
    logic [7:0]        rx_length;
    logic [7:0]        link_quality_raw;
    logic [6:0]        tx_length;
  } item_t;

  typedef struct packed {
    logic [2:0]        confirm_kind;
    logic [3:0]        status_code;
    logic [3:0]        radio_action;
    logic [8:0]        frequency_word;
    logic signed [7:0] energy_level;
    logic [6:0]        link_quality;
    logic [6:0]        frame_length;
    logic              settle_start;
    logic [3:0]        current_state;
  } result_t;

endpackage

// ===== sv/rtsc_in_stage.sv =====
module rtsc_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rtsc_pkg::item_t in_item,
  input  logic            take,
  output rtsc_pkg::item_t item,
  output logic            full
);

  // Accept a beat when empty or when the held beat moves on this cycle
  assign in_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // Capture the payload on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== sv/rtsc_decode.sv =====
module rtsc_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [4:0]        cfg_data,
  input  logic              fire,
  input  rtsc_pkg::item_t   item,
  output rtsc_pkg::result_t res
);

  rtsc_pkg::state_t  radio_state, radio_state_next;
  logic              defer_pending, defer_pending_next;
  logic [2:0]        deferred_target, deferred_target_next;
  logic [4:0]        channel_number;

  rtsc_pkg::cmd_t    cmd;
  rtsc_pkg::tgt_t    tgt;
  rtsc_pkg::tgt_t    dtgt;
  logic              below_idle;
  logic              oversized;
  logic              tgt_valid;

  rtsc_pkg::kind_t   kind;
  rtsc_pkg::status_t status;
  rtsc_pkg::action_t action;
  logic signed [7:0] energy;
  logic [6:0]        lq;
  logic [6:0]        flen;
  logic              tstart;
  logic signed [8:0] rssi_ext;
  logic signed [8:0] rssi_adj;
  logic [9:0]        freq_sum;

  assign cmd        = rtsc_pkg::cmd_t'(item.command);
  assign tgt        = rtsc_pkg::tgt_t'(item.target_state);
  assign dtgt       = rtsc_pkg::tgt_t'(deferred_target);
  assign tgt_valid  = item.target_state <= 3'(rtsc_pkg::TGT_FORCE_OFF);
  assign below_idle = radio_state inside {[rtsc_pkg::ST_REG_OFF:rtsc_pkg::ST_WAIT_OSC]};
  assign oversized  = item.rx_length > rtsc_pkg::MaxFrameLen;

  // Energy: rssi minus offset; below the floor value the minimum energy is used instead
  assign rssi_ext = 9'(item.rssi_raw);
  assign rssi_adj = rssi_ext - rtsc_pkg::RssiOffset;

  // Synthesizer word: base + 5 * channel
  assign freq_sum = rtsc_pkg::FreqBase + {5'd0, channel_number} + {3'd0, channel_number, 2'd0};

  // Next state
  always_comb begin
    radio_state_next     = radio_state;
    defer_pending_next   = defer_pending;
    deferred_target_next = deferred_target;
    case (cmd)
      rtsc_pkg::CMD_POWER_UP: begin
        if (radio_state == rtsc_pkg::ST_REG_OFF) radio_state_next = rtsc_pkg::ST_WAIT_REG_ON;
      end
      rtsc_pkg::CMD_POWER_DOWN: begin
        if (!(radio_state inside {rtsc_pkg::ST_REG_OFF, rtsc_pkg::ST_WAIT_REG_OFF})) begin
          radio_state_next = rtsc_pkg::ST_WAIT_REG_OFF;
        end
      end
      rtsc_pkg::CMD_TIMER: begin
        if (radio_state == rtsc_pkg::ST_WAIT_REG_ON) begin
          radio_state_next = rtsc_pkg::ST_POWERED_DOWN;
        end else if (radio_state == rtsc_pkg::ST_WAIT_REG_OFF) begin
          radio_state_next = rtsc_pkg::ST_REG_OFF;
        end
      end
      rtsc_pkg::CMD_POLL: begin
        case (radio_state)
          rtsc_pkg::ST_POWERED_DOWN: radio_state_next = rtsc_pkg::ST_WAIT_OSC;
          rtsc_pkg::ST_WAIT_OSC: begin
            if (item.osc_stable) radio_state_next = rtsc_pkg::ST_IDLE;
          end
          rtsc_pkg::ST_RX_READ: begin
            if (!oversized) begin
              radio_state_next = rtsc_pkg::ST_RX;
              if (defer_pending) begin
                defer_pending_next = 1'b0;
                if (dtgt == rtsc_pkg::TGT_TX_ON) radio_state_next = rtsc_pkg::ST_TX;
                else if (dtgt == rtsc_pkg::TGT_OFF) radio_state_next = rtsc_pkg::ST_IDLE;
              end
            end
          end
          rtsc_pkg::ST_TX_SFD: begin
            if (!item.tx_active) begin
              radio_state_next = rtsc_pkg::ST_TX;
              if (defer_pending) begin
                defer_pending_next = 1'b0;
                if (dtgt == rtsc_pkg::TGT_RX_ON) radio_state_next = rtsc_pkg::ST_RX;
                else if (dtgt == rtsc_pkg::TGT_RX_REJECT) radio_state_next = rtsc_pkg::ST_RX_REJECT;
                else if (dtgt == rtsc_pkg::TGT_OFF) radio_state_next = rtsc_pkg::ST_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      rtsc_pkg::CMD_SFD: begin
        if (radio_state == rtsc_pkg::ST_RX) radio_state_next = rtsc_pkg::ST_RX_SFD;
        else if (radio_state == rtsc_pkg::ST_TX) radio_state_next = rtsc_pkg::ST_TX_SFD;
      end
      rtsc_pkg::CMD_FIFOP: begin
        if (radio_state == rtsc_pkg::ST_RX_SFD) radio_state_next = rtsc_pkg::ST_RX_READ;
      end
      rtsc_pkg::CMD_SET_STATE: begin
        if (!below_idle) begin
          defer_pending_next   = 1'b0;
          deferred_target_next = item.target_state;
          case (tgt)
            rtsc_pkg::TGT_RX_ON: begin
              if (radio_state inside {rtsc_pkg::ST_RX, rtsc_pkg::ST_RX_SFD}) ;
              else if (radio_state == rtsc_pkg::ST_TX_SFD) defer_pending_next = 1'b1;
              else radio_state_next = rtsc_pkg::ST_RX;
            end
            rtsc_pkg::TGT_RX_REJECT: begin
              if (radio_state == rtsc_pkg::ST_RX_REJECT) ;
              else if (radio_state == rtsc_pkg::ST_TX_SFD) defer_pending_next = 1'b1;
              else radio_state_next = rtsc_pkg::ST_RX_REJECT;
            end
            rtsc_pkg::TGT_TX_ON: begin
              if (radio_state inside {rtsc_pkg::ST_TX, rtsc_pkg::ST_TX_SFD}) ;
              else if (radio_state == rtsc_pkg::ST_RX_SFD) defer_pending_next = 1'b1;
              else radio_state_next = rtsc_pkg::ST_TX;
            end
            rtsc_pkg::TGT_OFF: begin
              if (radio_state == rtsc_pkg::ST_IDLE) ;
              else if (radio_state inside {rtsc_pkg::ST_RX_SFD, rtsc_pkg::ST_TX_SFD}) begin
                defer_pending_next = 1'b1;
              end else radio_state_next = rtsc_pkg::ST_IDLE;
            end
            rtsc_pkg::TGT_FORCE_OFF: radio_state_next = rtsc_pkg::ST_IDLE;
            default: ;
          endcase
        end
      end
      rtsc_pkg::CMD_TRANSMIT: begin
        if (!below_idle && item.tx_length != 7'd0 &&
            !(radio_state inside {rtsc_pkg::ST_IDLE, rtsc_pkg::ST_RX,
                                  rtsc_pkg::ST_RX_SFD, rtsc_pkg::ST_RX_REJECT})) begin
          radio_state_next = rtsc_pkg::ST_TX;
        end
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    kind   = rtsc_pkg::KIND_NONE;
    status = rtsc_pkg::STAT_SUCCESS;
    action = rtsc_pkg::ACT_NONE;
    energy = 8'sd0;
    lq     = 7'd0;
    flen   = 7'd0;
    tstart = 1'b0;
    case (cmd)
      rtsc_pkg::CMD_POWER_UP: begin
        if (radio_state == rtsc_pkg::ST_REG_OFF) begin
          tstart = 1'b1;
        end else begin
          kind   = rtsc_pkg::KIND_REJECTED;
          status = rtsc_pkg::STAT_POWERED_UP;
        end
      end
      rtsc_pkg::CMD_POWER_DOWN: begin
        if (!(radio_state inside {rtsc_pkg::ST_REG_OFF, rtsc_pkg::ST_WAIT_REG_OFF})) begin
          action = rtsc_pkg::ACT_RESET_OSC_OFF;
          tstart = 1'b1;
        end else begin
          kind   = rtsc_pkg::KIND_REJECTED;
          status = rtsc_pkg::STAT_POWERED_DOWN;
        end
      end
      rtsc_pkg::CMD_TIMER: begin
        if (radio_state == rtsc_pkg::ST_WAIT_REG_OFF) begin
          kind   = rtsc_pkg::KIND_CHANGED;
          status = rtsc_pkg::STAT_POWERED_DOWN;
        end
      end
      rtsc_pkg::CMD_POLL: begin
        case (radio_state)
          rtsc_pkg::ST_POWERED_DOWN: action = rtsc_pkg::ACT_RESET_OSC_ON;
          rtsc_pkg::ST_WAIT_OSC: begin
            if (item.osc_stable) begin
              action = rtsc_pkg::ACT_CONFIGURE;
              kind   = rtsc_pkg::KIND_CHANGED;
              status = rtsc_pkg::STAT_POWERED_UP;
            end
          end
          rtsc_pkg::ST_RX_READ: begin
            action = rtsc_pkg::ACT_FLUSH_RX;
            if (!oversized) begin
              if (item.rx_length != 8'd0) begin
                lq   = item.link_quality_raw[7] ? ~item.link_quality_raw[6:0]
                                                :  item.link_quality_raw[6:0];
                flen = item.rx_length[6:0];
                kind = rtsc_pkg::KIND_FRAME;
              end
              if (defer_pending && (dtgt inside {rtsc_pkg::TGT_TX_ON, rtsc_pkg::TGT_OFF})) begin
                action = rtsc_pkg::ACT_RF_OFF;
              end
            end
          end
          rtsc_pkg::ST_RX_REJECT: action = rtsc_pkg::ACT_FLUSH_RX;
          rtsc_pkg::ST_TX_SFD: begin
            if (!item.tx_active) begin
              action = rtsc_pkg::ACT_RF_OFF;
              if (defer_pending &&
                  (dtgt inside {rtsc_pkg::TGT_RX_ON, rtsc_pkg::TGT_RX_REJECT})) begin
                action = rtsc_pkg::ACT_RX_ON;
              end
              kind = rtsc_pkg::KIND_DATA;
            end
          end
          default: ;
        endcase
      end
      rtsc_pkg::CMD_SET_STATE: begin
        if (below_idle) begin
          kind   = rtsc_pkg::KIND_REJECTED;
          status = rtsc_pkg::STAT_OFF;
        end else if (tgt_valid) begin
          kind = rtsc_pkg::KIND_SET_STATE;
          case (tgt)
            rtsc_pkg::TGT_RX_ON: begin
              if (radio_state inside {rtsc_pkg::ST_RX, rtsc_pkg::ST_RX_SFD}) begin
                status = rtsc_pkg::STAT_RX_ON;
              end else if (radio_state == rtsc_pkg::ST_TX_SFD) begin
                status = rtsc_pkg::STAT_BUSY_TX;
              end else action = rtsc_pkg::ACT_RX_ON;
            end
            rtsc_pkg::TGT_RX_REJECT: begin
              if (radio_state == rtsc_pkg::ST_RX_REJECT) status = rtsc_pkg::STAT_RX_ON;
              else if (radio_state == rtsc_pkg::ST_TX_SFD) status = rtsc_pkg::STAT_BUSY_TX;
              else action = rtsc_pkg::ACT_RX_ON;
            end
            rtsc_pkg::TGT_TX_ON: begin
              if (radio_state inside {rtsc_pkg::ST_TX, rtsc_pkg::ST_TX_SFD}) begin
                status = rtsc_pkg::STAT_TX_ON;
              end else if (radio_state == rtsc_pkg::ST_RX_SFD) begin
                status = rtsc_pkg::STAT_BUSY_RX;
              end else action = rtsc_pkg::ACT_RF_OFF;
            end
            rtsc_pkg::TGT_OFF: begin
              if (radio_state == rtsc_pkg::ST_IDLE) status = rtsc_pkg::STAT_OFF;
              else if (radio_state == rtsc_pkg::ST_RX_SFD) status = rtsc_pkg::STAT_BUSY_RX;
              else if (radio_state == rtsc_pkg::ST_TX_SFD) status = rtsc_pkg::STAT_BUSY_TX;
              else action = rtsc_pkg::ACT_RF_OFF;
            end
            default: action = rtsc_pkg::ACT_RF_OFF;
          endcase
        end
      end
      rtsc_pkg::CMD_CCA, rtsc_pkg::CMD_ENERGY: begin
        if (below_idle) begin
          kind   = rtsc_pkg::KIND_REJECTED;
          status = rtsc_pkg::STAT_OFF;
        end else begin
          kind = (cmd == rtsc_pkg::CMD_CCA) ? rtsc_pkg::KIND_CCA : rtsc_pkg::KIND_ENERGY;
          if (radio_state == rtsc_pkg::ST_IDLE) begin
            status = rtsc_pkg::STAT_OFF;
          end else if (radio_state inside {rtsc_pkg::ST_TX, rtsc_pkg::ST_TX_SFD}) begin
            status = rtsc_pkg::STAT_TX_ON;
          end else if (cmd == rtsc_pkg::CMD_CCA) begin
            status = item.channel_clear ? rtsc_pkg::STAT_IDLE : rtsc_pkg::STAT_BUSY;
          end else begin
            energy = (rssi_ext < rtsc_pkg::RssiFloor) ? rtsc_pkg::EnergyMin : rssi_adj[7:0];
          end
        end
      end
      rtsc_pkg::CMD_TRANSMIT: begin
        if (below_idle) begin
          kind   = rtsc_pkg::KIND_REJECTED;
          status = rtsc_pkg::STAT_OFF;
        end else if (item.tx_length == 7'd0) begin
          kind = rtsc_pkg::KIND_REJECTED;
        end else if (radio_state == rtsc_pkg::ST_IDLE) begin
          kind   = rtsc_pkg::KIND_DATA;
          status = rtsc_pkg::STAT_OFF;
        end else if (radio_state inside {rtsc_pkg::ST_RX, rtsc_pkg::ST_RX_SFD,
                                         rtsc_pkg::ST_RX_REJECT}) begin
          kind   = rtsc_pkg::KIND_DATA;
          status = rtsc_pkg::STAT_RX_ON;
        end else begin
          action = item.tx_underflow ? rtsc_pkg::ACT_FLUSH_TX_LOAD : rtsc_pkg::ACT_TX_START;
        end
      end
      default: ;
    endcase
  end

  // Assemble the result beat
  always_comb begin
    res.confirm_kind   = kind;
    res.status_code    = status;
    res.radio_action   = action;
    res.frequency_word = freq_sum[8:0];
    res.energy_level   = energy;
    res.link_quality   = lq;
    res.frame_length   = flen;
    res.settle_start   = tstart;
    res.current_state  = radio_state_next;
  end

  // Advance state when a beat is decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      radio_state     <= rtsc_pkg::ST_REG_OFF;
      defer_pending   <= 1'b0;
      deferred_target <= 3'(rtsc_pkg::TGT_RX_ON);
    end else if (fire) begin
      radio_state     <= radio_state_next;
      defer_pending   <= defer_pending_next;
      deferred_target <= deferred_target_next;
    end
  end

  // Channel register
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_number <= rtsc_pkg::ChannelReset;
    end else if (cfg_write) begin
      channel_number <= cfg_data;
    end
  end

endmodule

// ===== sv/rtsc_out_stage.sv =====
module rtsc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rtsc_pkg::result_t res_in,
  output logic              out_valid,
  input  logic              out_ready,
  output rtsc_pkg::result_t res
);

  // Hold the beat until taken; load only when empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

// ===== sv/radio_transceiver_state_controller_core.sv =====
// Radio state controller for a low-rate radio PHY: each input beat is one event
// (power, timer, poll, frame start, threshold, state request, CCA, energy,
// transmit) and produces exactly one result beat with confirm, status, radio
// action, frequency word, energy, frame indication, settle timer start and new
// state. One beat is accepted per cycle while the result side does not stall; a beat
// is held in the input register, then decoded into the result register, which
// raises out_valid, and the decode also updates the radio state. in_ready drops
// only while both registers hold a beat and the result side stalls. Write
// channel_number only while no beat is in flight.
module radio_transceiver_state_controller_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [4:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        command,
  input  logic [2:0]        target_state,
  input  logic              osc_stable,
  input  logic              tx_active,
  input  logic              tx_underflow,
  input  logic              channel_clear,
  input  logic signed [7:0] rssi_raw,
  input  logic [7:0]        rx_length,
  input  logic [7:0]        link_quality_raw,
  input  logic [6:0]        tx_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        confirm_kind,
  output logic [3:0]        status_code,
  output logic [3:0]        radio_action,
  output logic [8:0]        frequency_word,
  output logic signed [7:0] energy_level,
  output logic [6:0]        link_quality,
  output logic [6:0]        frame_length,
  output logic              settle_start,
  output logic [3:0]        current_state
);

  rtsc_pkg::item_t   in_item;
  rtsc_pkg::item_t   item;
  rtsc_pkg::result_t res_dec;
  rtsc_pkg::result_t res;
  logic              full;
  logic              take;

  // Pack the input beat
  always_comb begin
    in_item.command          = command;
    in_item.target_state     = target_state;
    in_item.osc_stable       = osc_stable;
    in_item.tx_active        = tx_active;
    in_item.tx_underflow     = tx_underflow;
    in_item.channel_clear    = channel_clear;
    in_item.rssi_raw         = rssi_raw;
    in_item.rx_length        = rx_length;
    in_item.link_quality_raw = link_quality_raw;
    in_item.tx_length        = tx_length;
  end

  // Decode the held beat when the result register can take it
  assign take = full && (!out_valid || out_ready);

  rtsc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .item     (item),
    .full     (full)
  );

  rtsc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .fire      (take),
    .item      (item),
    .res       (res_dec)
  );

  rtsc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res_in    (res_dec),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Unpack the result beat
  assign confirm_kind   = res.confirm_kind;
  assign status_code    = res.status_code;
  assign radio_action   = res.radio_action;
  assign frequency_word = res.frequency_word;
  assign energy_level   = res.energy_level;
  assign link_quality   = res.link_quality;
  assign frame_length   = res.frame_length;
  assign settle_start   = res.settle_start;
  assign current_state  = res.current_state;

`ifndef SYNTHESIS
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !full |-> in_ready)
    else $error("input stage empty but not ready");

  a_none_success: assert property (@(posedge clk) disable iff (rst)
    out_valid && confirm_kind == rtsc_pkg::KIND_NONE |->
      status_code == rtsc_pkg::STAT_SUCCESS)
    else $error("status set without a confirm");

  a_timer_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && settle_start |->
      current_state == rtsc_pkg::ST_WAIT_REG_ON || current_state == rtsc_pkg::ST_WAIT_REG_OFF)
    else $error("timer started outside a regulator wait state");

  a_energy_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && energy_level != 8'sd0 |-> confirm_kind == rtsc_pkg::KIND_ENERGY)
    else $error("energy level without energy confirm");

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("decoded beat not presented");
`endif

endmodule

// ===== sim/tb_radio_transceiver_state_controller_core.sv =====
`timescale 1ns / 1ps

module tb_radio_transceiver_state_controller_core;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [3:0]  CMD_UNUSED = 4'hF;
  localparam logic [2:0]  TGT_UNDEFINED = 3'd7;

  // Track radio state and deferred change; queue the confirm each event must produce
  class confirm_scoreboard;
    rtsc_pkg::state_t  rstate;
    bit                defer_on;
    logic [2:0]        defer_tgt;
    logic [4:0]        channel;
    rtsc_pkg::result_t pending_confirms[$];
    int                mismatches;
    int                beats;

    function new();
      rstate     = rtsc_pkg::ST_REG_OFF;
      defer_on   = 1'b0;
      defer_tgt  = '0;
      channel    = rtsc_pkg::ChannelReset;
      mismatches = 0;
      beats      = 0;
    endfunction

    task report_mismatch(string what, int got_v, int want_v);
      mismatches++;
      $display("mismatch at result beat %0d: %s got %0d expected %0d",
               beats, what, got_v, want_v);
    endtask

    // Decode one event into its confirm and advance the tracked state
    function rtsc_pkg::result_t decode_event(rtsc_pkg::item_t ev);
      rtsc_pkg::result_t r;
      rtsc_pkg::state_t  s;
      logic [7:0]        lq_byte;
      int                e;
      r = '0;
      s = rstate;
      case (ev.command)
        rtsc_pkg::CMD_POWER_UP:
          if (s == rtsc_pkg::ST_REG_OFF) begin
            rstate         = rtsc_pkg::ST_WAIT_REG_ON;
            r.settle_start = 1'b1;
          end else begin
            r.confirm_kind = rtsc_pkg::KIND_REJECTED;
            r.status_code  = rtsc_pkg::STAT_POWERED_UP;
          end
        rtsc_pkg::CMD_POWER_DOWN:
          if (s != rtsc_pkg::ST_REG_OFF && s != rtsc_pkg::ST_WAIT_REG_OFF) begin
            r.radio_action = rtsc_pkg::ACT_RESET_OSC_OFF;
            rstate         = rtsc_pkg::ST_WAIT_REG_OFF;
            r.settle_start = 1'b1;
          end else begin
            r.confirm_kind = rtsc_pkg::KIND_REJECTED;
            r.status_code  = rtsc_pkg::STAT_POWERED_DOWN;
          end
        rtsc_pkg::CMD_TIMER:
          if (s == rtsc_pkg::ST_WAIT_REG_ON) begin
            rstate = rtsc_pkg::ST_POWERED_DOWN;
          end else if (s == rtsc_pkg::ST_WAIT_REG_OFF) begin
            rstate         = rtsc_pkg::ST_REG_OFF;
            r.confirm_kind = rtsc_pkg::KIND_CHANGED;
            r.status_code  = rtsc_pkg::STAT_POWERED_DOWN;
          end
        rtsc_pkg::CMD_POLL:
          case (s)
            rtsc_pkg::ST_POWERED_DOWN: begin
              r.radio_action = rtsc_pkg::ACT_RESET_OSC_ON;
              rstate         = rtsc_pkg::ST_WAIT_OSC;
            end
            rtsc_pkg::ST_WAIT_OSC:
              if (ev.osc_stable) begin
                r.radio_action = rtsc_pkg::ACT_CONFIGURE;
                rstate         = rtsc_pkg::ST_IDLE;
                r.confirm_kind = rtsc_pkg::KIND_CHANGED;
                r.status_code  = rtsc_pkg::STAT_POWERED_UP;
              end
            rtsc_pkg::ST_RX_READ: begin
              // Flush always; an oversized frame leaves the state alone
              r.radio_action = rtsc_pkg::ACT_FLUSH_RX;
              if (ev.rx_length <= rtsc_pkg::MaxFrameLen) begin
                if (ev.rx_length != 0) begin
                  lq_byte = ev.link_quality_raw[7] ? ~ev.link_quality_raw
                                                   : ev.link_quality_raw;
                  r.link_quality = lq_byte[6:0];
                  r.frame_length = ev.rx_length[6:0];
                  r.confirm_kind = rtsc_pkg::KIND_FRAME;
                  r.status_code  = rtsc_pkg::STAT_SUCCESS;
                end
                rstate = rtsc_pkg::ST_RX;
                if (defer_on) begin
                  defer_on = 1'b0;
                  if (defer_tgt == rtsc_pkg::TGT_TX_ON) begin
                    r.radio_action = rtsc_pkg::ACT_RF_OFF;
                    rstate         = rtsc_pkg::ST_TX;
                  end else if (defer_tgt == rtsc_pkg::TGT_OFF) begin
                    r.radio_action = rtsc_pkg::ACT_RF_OFF;
                    rstate         = rtsc_pkg::ST_IDLE;
                  end
                end
              end
            end
            rtsc_pkg::ST_RX_REJECT: r.radio_action = rtsc_pkg::ACT_FLUSH_RX;
            rtsc_pkg::ST_TX_SFD:
              if (!ev.tx_active) begin
                r.radio_action = rtsc_pkg::ACT_RF_OFF;
                rstate         = rtsc_pkg::ST_TX;
                if (defer_on) begin
                  defer_on = 1'b0;
                  if (defer_tgt == rtsc_pkg::TGT_RX_ON) begin
                    r.radio_action = rtsc_pkg::ACT_RX_ON;
                    rstate         = rtsc_pkg::ST_RX;
                  end else if (defer_tgt == rtsc_pkg::TGT_RX_REJECT) begin
                    r.radio_action = rtsc_pkg::ACT_RX_ON;
                    rstate         = rtsc_pkg::ST_RX_REJECT;
                  end else if (defer_tgt == rtsc_pkg::TGT_OFF) begin
                    rstate = rtsc_pkg::ST_IDLE;
                  end
                end
                r.confirm_kind = rtsc_pkg::KIND_DATA;
                r.status_code  = rtsc_pkg::STAT_SUCCESS;
              end
            default: ;
          endcase
        rtsc_pkg::CMD_SFD:
          if (s == rtsc_pkg::ST_RX) rstate = rtsc_pkg::ST_RX_SFD;
          else if (s == rtsc_pkg::ST_TX) rstate = rtsc_pkg::ST_TX_SFD;
        rtsc_pkg::CMD_FIFOP:
          if (s == rtsc_pkg::ST_RX_SFD) rstate = rtsc_pkg::ST_RX_READ;
        rtsc_pkg::CMD_SET_STATE:
          if (s < rtsc_pkg::ST_IDLE) begin
            r.confirm_kind = rtsc_pkg::KIND_REJECTED;
            r.status_code  = rtsc_pkg::STAT_OFF;
          end else begin
            // Any request drops a pending deferral; undefined targets stop here
            defer_on  = 1'b0;
            defer_tgt = ev.target_state;
            if (ev.target_state <= rtsc_pkg::TGT_FORCE_OFF) begin
              r.confirm_kind = rtsc_pkg::KIND_SET_STATE;
              r.status_code  = rtsc_pkg::STAT_SUCCESS;
              case (ev.target_state)
                rtsc_pkg::TGT_RX_ON:
                  if (s == rtsc_pkg::ST_RX || s == rtsc_pkg::ST_RX_SFD) begin
                    r.status_code = rtsc_pkg::STAT_RX_ON;
                  end else if (s == rtsc_pkg::ST_TX_SFD) begin
                    defer_on      = 1'b1;
                    r.status_code = rtsc_pkg::STAT_BUSY_TX;
                  end else begin
                    r.radio_action = rtsc_pkg::ACT_RX_ON;
                    rstate         = rtsc_pkg::ST_RX;
                  end
                rtsc_pkg::TGT_RX_REJECT:
                  if (s == rtsc_pkg::ST_RX_REJECT) begin
                    r.status_code = rtsc_pkg::STAT_RX_ON;
                  end else if (s == rtsc_pkg::ST_TX_SFD) begin
                    defer_on      = 1'b1;
                    r.status_code = rtsc_pkg::STAT_BUSY_TX;
                  end else begin
                    r.radio_action = rtsc_pkg::ACT_RX_ON;
                    rstate         = rtsc_pkg::ST_RX_REJECT;
                  end
                rtsc_pkg::TGT_TX_ON:
                  if (s == rtsc_pkg::ST_TX || s == rtsc_pkg::ST_TX_SFD) begin
                    r.status_code = rtsc_pkg::STAT_TX_ON;
                  end else if (s == rtsc_pkg::ST_RX_SFD) begin
                    defer_on      = 1'b1;
                    r.status_code = rtsc_pkg::STAT_BUSY_RX;
                  end else begin
                    r.radio_action = rtsc_pkg::ACT_RF_OFF;
                    rstate         = rtsc_pkg::ST_TX;
                  end
                rtsc_pkg::TGT_OFF:
                  if (s == rtsc_pkg::ST_IDLE) begin
                    r.status_code = rtsc_pkg::STAT_OFF;
                  end else if (s == rtsc_pkg::ST_RX_SFD) begin
                    defer_on      = 1'b1;
                    r.status_code = rtsc_pkg::STAT_BUSY_RX;
                  end else if (s == rtsc_pkg::ST_TX_SFD) begin
                    defer_on      = 1'b1;
                    r.status_code = rtsc_pkg::STAT_BUSY_TX;
                  end else begin
                    r.radio_action = rtsc_pkg::ACT_RF_OFF;
                    rstate         = rtsc_pkg::ST_IDLE;
                  end
                default: begin
                  r.radio_action = rtsc_pkg::ACT_RF_OFF;
                  rstate         = rtsc_pkg::ST_IDLE;
                end
              endcase
            end
          end
        rtsc_pkg::CMD_CCA:
          if (s < rtsc_pkg::ST_IDLE) begin
            r.confirm_kind = rtsc_pkg::KIND_REJECTED;
            r.status_code  = rtsc_pkg::STAT_OFF;
          end else begin
            r.confirm_kind = rtsc_pkg::KIND_CCA;
            if (s == rtsc_pkg::ST_IDLE) begin
              r.status_code = rtsc_pkg::STAT_OFF;
            end else if (s == rtsc_pkg::ST_TX || s == rtsc_pkg::ST_TX_SFD) begin
              r.status_code = rtsc_pkg::STAT_TX_ON;
            end else begin
              r.status_code = ev.channel_clear ? rtsc_pkg::STAT_IDLE : rtsc_pkg::STAT_BUSY;
            end
          end
        rtsc_pkg::CMD_ENERGY:
          if (s < rtsc_pkg::ST_IDLE) begin
            r.confirm_kind = rtsc_pkg::KIND_REJECTED;
            r.status_code  = rtsc_pkg::STAT_OFF;
          end else begin
            r.confirm_kind = rtsc_pkg::KIND_ENERGY;
            if (s == rtsc_pkg::ST_IDLE) begin
              r.status_code = rtsc_pkg::STAT_OFF;
            end else if (s == rtsc_pkg::ST_TX || s == rtsc_pkg::ST_TX_SFD) begin
              r.status_code = rtsc_pkg::STAT_TX_ON;
            end else begin
              // Weak signals below the floor read as -127, else offset by 45
              e = $signed(ev.rssi_raw);
              e = (e < -81) ? -127 : e - 45;
              r.energy_level = 8'(e);
              r.status_code  = rtsc_pkg::STAT_SUCCESS;
            end
          end
        rtsc_pkg::CMD_TRANSMIT:
          if (s < rtsc_pkg::ST_IDLE) begin
            r.confirm_kind = rtsc_pkg::KIND_REJECTED;
            r.status_code  = rtsc_pkg::STAT_OFF;
          end else if (ev.tx_length == 0) begin
            r.confirm_kind = rtsc_pkg::KIND_REJECTED;
            r.status_code  = rtsc_pkg::STAT_SUCCESS;
          end else if (s == rtsc_pkg::ST_IDLE) begin
            r.confirm_kind = rtsc_pkg::KIND_DATA;
            r.status_code  = rtsc_pkg::STAT_OFF;
          end else if (s == rtsc_pkg::ST_RX || s == rtsc_pkg::ST_RX_SFD ||
                       s == rtsc_pkg::ST_RX_REJECT) begin
            r.confirm_kind = rtsc_pkg::KIND_DATA;
            r.status_code  = rtsc_pkg::STAT_RX_ON;
          end else begin
            r.radio_action = ev.tx_underflow ? rtsc_pkg::ACT_FLUSH_TX_LOAD
                                             : rtsc_pkg::ACT_TX_START;
            rstate         = rtsc_pkg::ST_TX;
          end
        default: ;
      endcase
      r.frequency_word = 9'((357 + 5 * (int'(channel) - 11)) & 511);
      r.current_state  = rstate;
      return r;
    endfunction

    function void take_event(rtsc_pkg::item_t ev);
      pending_confirms.push_back(decode_event(ev));
    endfunction

    function int outstanding();
      return pending_confirms.size();
    endfunction

    // Compare one result beat against the oldest queued confirm
    task match_confirm(rtsc_pkg::result_t got);
      rtsc_pkg::result_t want;
      beats++;
      if (pending_confirms.size() == 0) begin
        report_mismatch("result beat with nothing queued, state", got.current_state, 0);
        return;
      end
      want = pending_confirms.pop_front();
      if (got.confirm_kind != want.confirm_kind)
        report_mismatch("confirm_kind", got.confirm_kind, want.confirm_kind);
      if (got.status_code != want.status_code)
        report_mismatch("status_code", got.status_code, want.status_code);
      if (got.radio_action != want.radio_action)
        report_mismatch("radio_action", got.radio_action, want.radio_action);
      if (got.frequency_word != want.frequency_word)
        report_mismatch("frequency_word", got.frequency_word, want.frequency_word);
      if (got.energy_level != want.energy_level)
        report_mismatch("energy_level", got.energy_level, want.energy_level);
      if (got.link_quality != want.link_quality)
        report_mismatch("link_quality", got.link_quality, want.link_quality);
      if (got.frame_length != want.frame_length)
        report_mismatch("frame_length", got.frame_length, want.frame_length);
      if (got.settle_start != want.settle_start)
        report_mismatch("settle_start", got.settle_start, want.settle_start);
      if (got.current_state != want.current_state)
        report_mismatch("current_state", got.current_state, want.current_state);
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_write = 1'b0;
  logic [4:0]      cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            out_valid;
  logic            out_ready = 1'b1;
  rtsc_pkg::item_t cur = '0;
  bit              quiet = 1'b0;
  int unsigned     cycles = 0;

  logic [2:0]        confirm_kind;
  logic [3:0]        status_code;
  logic [3:0]        radio_action;
  logic [8:0]        frequency_word;
  logic signed [7:0] energy_level;
  logic [6:0]        link_quality;
  logic [6:0]        frame_length;
  logic              settle_start;
  logic [3:0]        current_state;

  confirm_scoreboard sb;

  radio_transceiver_state_controller_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (cur.command),
    .target_state     (cur.target_state),
    .osc_stable       (cur.osc_stable),
    .tx_active        (cur.tx_active),
    .tx_underflow     (cur.tx_underflow),
    .channel_clear    (cur.channel_clear),
    .rssi_raw         (cur.rssi_raw),
    .rx_length        (cur.rx_length),
    .link_quality_raw (cur.link_quality_raw),
    .tx_length        (cur.tx_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .confirm_kind     (confirm_kind),
    .status_code      (status_code),
    .radio_action     (radio_action),
    .frequency_word   (frequency_word),
    .energy_level     (energy_level),
    .link_quality     (link_quality),
    .frame_length     (frame_length),
    .settle_start     (settle_start),
    .current_state    (current_state)
  );

  always #5 clk = ~clk;

  // Stall the result side at random unless in a quiet phase
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 13);
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.take_event(cur);
      if (out_valid && out_ready)
        sb.match_confirm({confirm_kind, status_code, radio_action, frequency_word,
                          energy_level, link_quality, frame_length, settle_start,
                          current_state});
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL radio_transceiver_state_controller_core");
      $finish;
    end
  end

  // Random event, mostly one that moves the current state forward
  function automatic rtsc_pkg::item_t pick_event(rtsc_pkg::state_t s);
    rtsc_pkg::item_t it;
    int              roll;
    it.command          = 4'($urandom_range(15));
    it.target_state     = 3'($urandom_range(7));
    it.osc_stable       = ($urandom_range(3) != 0);
    it.tx_active        = ($urandom_range(9) < 3);
    it.tx_underflow     = 1'($urandom_range(1));
    it.channel_clear    = 1'($urandom_range(1));
    it.rssi_raw         = 8'($urandom);
    roll = $urandom_range(99);
    it.rx_length = (roll < 15) ? 8'd0 :
                   (roll < 30) ? 8'($urandom_range(255, 128)) : 8'($urandom_range(127, 1));
    it.link_quality_raw = 8'($urandom);
    it.tx_length        = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom);
    if ($urandom_range(99) < 15)
      return it;
    if ($urandom_range(99) < 3) begin
      it.command = rtsc_pkg::CMD_POWER_DOWN;
      return it;
    end
    it.target_state = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                               : 3'($urandom_range(4));
    case (s)
      rtsc_pkg::ST_REG_OFF: it.command = rtsc_pkg::CMD_POWER_UP;
      rtsc_pkg::ST_WAIT_REG_ON, rtsc_pkg::ST_WAIT_REG_OFF: it.command = rtsc_pkg::CMD_TIMER;
      rtsc_pkg::ST_POWERED_DOWN, rtsc_pkg::ST_WAIT_OSC: it.command = rtsc_pkg::CMD_POLL;
      default:
        case ($urandom_range(9))
          0, 1:    it.command = rtsc_pkg::CMD_SET_STATE;
          2:       it.command = rtsc_pkg::CMD_CCA;
          3:       it.command = rtsc_pkg::CMD_ENERGY;
          4:       it.command = rtsc_pkg::CMD_TRANSMIT;
          5, 6:    it.command = rtsc_pkg::CMD_SFD;
          7:       it.command = rtsc_pkg::CMD_FIFOP;
          default: it.command = rtsc_pkg::CMD_POLL;
        endcase
    endcase
    return it;
  endfunction

  function automatic rtsc_pkg::item_t base_event(logic [3:0] cmd, logic [2:0] tgt);
    rtsc_pkg::item_t it;
    it                  = '0;
    it.command          = cmd;
    it.target_state     = tgt;
    it.osc_stable       = 1'b1;
    it.rx_length        = 8'd20;
    it.link_quality_raw = 8'h40;
    it.tx_length        = 7'd10;
    return it;
  endfunction

  // Present one beat after an optional gap; return at the falling edge after acceptance
  task automatic drive_beat(input rtsc_pkg::item_t it);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cur      = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain all results, let the pipeline settle, then write the channel
  task automatic set_channel(input logic [4:0] chan);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = chan;
    @(negedge clk);
    cfg_write  = 1'b0;
    sb.channel = chan;
  endtask

  task automatic run_random(input int count);
    rtsc_pkg::item_t it;
    int              done;
    done = 0;
    while (done < count) begin
      it = pick_event(sb.rstate);
      if (it.command <= rtsc_pkg::CMD_TRANSMIT) done++;
      drive_beat(it);
    end
  endtask

  // Walk power-up, receive with deferral, transmit with deferral, power-down
  task automatic run_directed();
    rtsc_pkg::item_t it;
    drive_beat(base_event(rtsc_pkg::CMD_TRANSMIT, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(CMD_UNUSED, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_POWER_DOWN, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_POWER_UP, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_POWER_UP, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_TIMER, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_POLL, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_POLL, rtsc_pkg::TGT_RX_ON));
    it = base_event(rtsc_pkg::CMD_TRANSMIT, rtsc_pkg::TGT_RX_ON);
    it.tx_length = 7'd0;
    drive_beat(it);
    drive_beat(base_event(rtsc_pkg::CMD_SET_STATE, rtsc_pkg::TGT_OFF));
    drive_beat(base_event(rtsc_pkg::CMD_SET_STATE, rtsc_pkg::TGT_RX_ON));
    it = base_event(rtsc_pkg::CMD_ENERGY, rtsc_pkg::TGT_RX_ON);
    it.rssi_raw = 8'h80;
    drive_beat(it);
    drive_beat(base_event(rtsc_pkg::CMD_SFD, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_FIFOP, rtsc_pkg::TGT_RX_ON));
    it = base_event(rtsc_pkg::CMD_POLL, rtsc_pkg::TGT_RX_ON);
    it.rx_length = 8'd128;
    drive_beat(it);
    it = base_event(rtsc_pkg::CMD_POLL, rtsc_pkg::TGT_RX_ON);
    it.rx_length        = 8'd127;
    it.link_quality_raw = 8'h80;
    drive_beat(it);
    drive_beat(base_event(rtsc_pkg::CMD_SFD, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_SET_STATE, rtsc_pkg::TGT_TX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_FIFOP, rtsc_pkg::TGT_RX_ON));
    it = base_event(rtsc_pkg::CMD_POLL, rtsc_pkg::TGT_RX_ON);
    it.rx_length = 8'd0;
    drive_beat(it);
    drive_beat(base_event(rtsc_pkg::CMD_SFD, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_SET_STATE, rtsc_pkg::TGT_RX_REJECT));
    drive_beat(base_event(rtsc_pkg::CMD_POLL, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_SET_STATE, rtsc_pkg::TGT_RX_REJECT));
    drive_beat(base_event(rtsc_pkg::CMD_SET_STATE, TGT_UNDEFINED));
    drive_beat(base_event(rtsc_pkg::CMD_POWER_DOWN, rtsc_pkg::TGT_RX_ON));
    drive_beat(base_event(rtsc_pkg::CMD_TIMER, rtsc_pkg::TGT_RX_ON));
  endtask

  initial begin
    logic [4:0] chan;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    // Sweep the channel across phases; one phase runs without any stalls
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       chan = 5'd0;
        1:       chan = 5'd31;
        2:       chan = 5'd26;
        3:       chan = 5'd11;
        default: chan = 5'($urandom_range(31));
      endcase
      set_channel(chan);
      quiet = (p == 2);
      run_random(117);
    end
    quiet    = 1'b0;
    in_valid = 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("PASS radio_transceiver_state_controller_core");
    else
      $display("FAIL radio_transceiver_state_controller_core");
    $finish;
  end

endmodule
